### rtl/box_non_max_suppression_macros.svh
// ----------------------------------------------------------------------------
// box_non_max_suppression_macros
// Assertion macros used by the box suppression controller.
// ----------------------------------------------------------------------------
`ifndef BOX_NON_MAX_SUPPRESSION_MACROS_SVH
`define BOX_NON_MAX_SUPPRESSION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BNMS_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bnms assertion failed");

// Next-cycle implication, disabled during reset.
`define BNMS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bnms assertion failed");

`endif

### rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// Types and command codes shared by the box suppression controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bnms_pkg;

  typedef struct packed {
    logic [15:0]        left_edge;
    logic [15:0]        top_edge;
    logic [15:0]        right_edge;
    logic [15:0]        bottom_edge;
    logic signed [15:0] box_score;
    logic               final_box;
  } box_in_t;

  typedef struct packed {
    logic [15:0]        kept_left;
    logic [15:0]        kept_top;
    logic [15:0]        kept_right;
    logic [15:0]        kept_bottom;
    logic signed [15:0] kept_score;
    logic               last_kept;
  } box_out_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic [15:0]        y2;
    logic [15:0]        x2;
    logic [15:0]        y1;
    logic [15:0]        x1;
  } entry_t;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_BEST_CLR = 4'd2;
  localparam op_t OP_SCAN     = 4'd3;
  localparam op_t OP_SEL_RD   = 4'd4;
  localparam op_t OP_SEL_CAP  = 4'd5;
  localparam op_t OP_AREA     = 4'd6;
  localparam op_t OP_GEOM     = 4'd7;
  localparam op_t OP_INTER    = 4'd8;
  localparam op_t OP_AREAB    = 4'd9;
  localparam op_t OP_DEN      = 4'd10;
  localparam op_t OP_PROD     = 4'd11;
  localparam op_t OP_TEST     = 4'd12;
  localparam op_t OP_FLUSH    = 4'd13;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic alive_bit;
    logic any_alive;
    logic best_found;
  } status_t;

  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LIMIT     = 2'd1;

endpackage

`default_nettype wire

### rtl/bnms_dp.sv
// ----------------------------------------------------------------------------
// bnms_dp
// Box store, alive flags, best-score search and the staged IoU test.
// ----------------------------------------------------------------------------
`default_nettype none

module bnms_dp import bnms_pkg::*; #(
  parameter int MAX_BOXES = 64,
  parameter int IDXW      = $clog2(MAX_BOXES)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cmd_t            cmd,
  input  wire logic [IDXW-1:0] addr,
  input  wire box_in_t         box,
  input  wire logic [7:0]      threshold,
  output status_t              status,
  output entry_t               kept_box
);

  entry_t mem [MAX_BOXES];
  entry_t rd_q;
  logic [IDXW-1:0] rd_addr;

  logic [MAX_BOXES-1:0] alive;
  logic                 best_found;
  logic signed [15:0]   best_score;
  logic [IDXW-1:0]      best_idx;

  entry_t               a_box;
  logic signed [33:0]   area_a;
  logic signed [16:0]   wx;
  logic signed [16:0]   wy;
  logic signed [16:0]   bwx;
  logic signed [16:0]   bwy;
  logic                 overlap;
  logic [31:0]          inter;
  logic signed [33:0]   area_b;
  logic [35:0]          den;
  logic [43:0]          prod;

  logic [15:0]        ix1, iy1, ix2, iy2;
  logic signed [16:0] awx, awy;
  logic [38:0]        numer;
  logic               suppress;

  assign rd_addr = (cmd.op == OP_SEL_RD) ? best_idx : addr;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[addr] <= '{score: box.box_score, y2: box.bottom_edge, x2: box.right_edge,
                     y1: box.top_edge, x1: box.left_edge};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    ix1 = (a_box.x1 > rd_q.x1) ? a_box.x1 : rd_q.x1;
    iy1 = (a_box.y1 > rd_q.y1) ? a_box.y1 : rd_q.y1;
    ix2 = (a_box.x2 < rd_q.x2) ? a_box.x2 : rd_q.x2;
    iy2 = (a_box.y2 < rd_q.y2) ? a_box.y2 : rd_q.y2;
    awx = $signed({1'b0, a_box.x2}) - $signed({1'b0, a_box.x1});
    awy = $signed({1'b0, a_box.y2}) - $signed({1'b0, a_box.y1});
    numer = {inter, 7'b0};
    // floor(numer / den) > threshold  <=>  numer >= (threshold + 1) * den, den > 0
    suppress = overlap && !den[35] && (den != '0) && ({5'b0, numer} >= prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive      <= '0;
      best_found <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD:     alive[addr] <= 1'b1;
        OP_BEST_CLR: best_found <= 1'b0;
        OP_SCAN: begin
          if (!best_found || (rd_q.score > best_score)) begin
            best_found <= 1'b1;
          end
        end
        OP_SEL_CAP:  alive[best_idx] <= 1'b0;
        OP_TEST: begin
          if (suppress) begin
            alive[addr] <= 1'b0;
          end
        end
        OP_FLUSH:    alive <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SCAN: begin
        if (!best_found || (rd_q.score > best_score)) begin
          best_score <= rd_q.score;
          best_idx   <= addr;
        end
      end
      OP_SEL_CAP: a_box  <= rd_q;
      OP_AREA:    area_a <= awx * awy;
      OP_GEOM: begin
        wx  <= $signed({1'b0, ix2}) - $signed({1'b0, ix1});
        wy  <= $signed({1'b0, iy2}) - $signed({1'b0, iy1});
        bwx <= $signed({1'b0, rd_q.x2}) - $signed({1'b0, rd_q.x1});
        bwy <= $signed({1'b0, rd_q.y2}) - $signed({1'b0, rd_q.y1});
      end
      OP_INTER: begin
        overlap <= (wx > 17'sd0) && (wy > 17'sd0);
        inter   <= wx[15:0] * wy[15:0];
      end
      OP_AREAB:   area_b <= bwx * bwy;
      OP_DEN:     den <= 36'(area_a) + 36'(area_b) - 36'(inter);
      OP_PROD:    prod <= ({1'b0, threshold} + 9'd1) * den[34:0];
      default: ;
    endcase
  end

  assign status = '{alive_bit: alive[addr], any_alive: |alive, best_found: best_found};
  assign kept_box = a_box;

endmodule

`default_nettype wire

### rtl/bnms_ctrl.sv
// ----------------------------------------------------------------------------
// bnms_ctrl
// Sequencer: load, best-score rounds, suppression sweep and emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_non_max_suppression_macros.svh"

module bnms_ctrl import bnms_pkg::*; #(
  parameter int MAX_BOXES = 64,
  parameter int IDXW      = $clog2(MAX_BOXES),
  parameter int CNTW      = $clog2(MAX_BOXES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            box_valid,
  input  wire logic            final_box,
  output logic                 box_stall,
  output logic                 kept_valid,
  input  wire logic            kept_stall,
  output logic                 last,
  input  wire logic [6:0]      limit,
  input  wire status_t         status,
  output cmd_t                 cmd,
  output logic [IDXW-1:0]      addr
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SEL_RD   = 4'd4;
  localparam logic [3:0] S_SEL_CAP  = 4'd5;
  localparam logic [3:0] S_AREA     = 4'd6;
  localparam logic [3:0] S_SUP_CHK  = 4'd7;
  localparam logic [3:0] S_GEOM     = 4'd8;
  localparam logic [3:0] S_INTER    = 4'd9;
  localparam logic [3:0] S_AREAB    = 4'd10;
  localparam logic [3:0] S_DEN      = 4'd11;
  localparam logic [3:0] S_PROD     = 4'd12;
  localparam logic [3:0] S_TEST     = 4'd13;
  localparam logic [3:0] S_EMIT     = 4'd14;
  localparam logic [3:0] S_FINISH   = 4'd15;

  logic [3:0]      state, state_next;
  logic [CNTW-1:0] idx, idx_next;
  logic [CNTW-1:0] count, count_next;
  logic [6:0]      kept, kept_next;
  logic            room;

  assign room      = count < CNTW'(MAX_BOXES);
  assign box_stall = (state != S_IDLE);
  assign kept_valid = (state == S_EMIT);
  assign last = (({1'b0, kept} + 8'd1) == {1'b0, limit}) || !status.any_alive;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    kept_next  = kept;
    cmd.op     = OP_NONE;
    addr       = idx[IDXW-1:0];
    case (state)
      S_IDLE: begin
        addr = count[IDXW-1:0];
        if (box_valid) begin
          if (room) begin
            cmd.op     = OP_LOAD;
            count_next = count + CNTW'(1);
          end
          if (final_box) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.op   = OP_BEST_CLR;
        idx_next = '0;
        state_next = (kept >= limit) ? S_FINISH : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (idx == count) begin
          state_next = status.best_found ? S_SEL_RD : S_FINISH;
        end else if (status.alive_bit) begin
          state_next = S_SCAN_CMP;
        end else begin
          idx_next = idx + CNTW'(1);
        end
      end
      S_SCAN_CMP: begin
        cmd.op     = OP_SCAN;
        idx_next   = idx + CNTW'(1);
        state_next = S_SCAN_CHK;
      end
      S_SEL_RD: begin
        cmd.op     = OP_SEL_RD;
        state_next = S_SEL_CAP;
      end
      S_SEL_CAP: begin
        cmd.op     = OP_SEL_CAP;
        state_next = S_AREA;
      end
      S_AREA: begin
        cmd.op     = OP_AREA;
        idx_next   = '0;
        state_next = S_SUP_CHK;
      end
      S_SUP_CHK: begin
        if (idx == count) begin
          state_next = S_EMIT;
        end else if (status.alive_bit) begin
          state_next = S_GEOM;
        end else begin
          idx_next = idx + CNTW'(1);
        end
      end
      S_GEOM: begin
        cmd.op = OP_GEOM;
        state_next = S_INTER;
      end
      S_INTER: begin
        cmd.op = OP_INTER;
        state_next = S_AREAB;
      end
      S_AREAB: begin
        cmd.op = OP_AREAB;
        state_next = S_DEN;
      end
      S_DEN: begin
        cmd.op = OP_DEN;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.op = OP_PROD;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.op     = OP_TEST;
        idx_next   = idx + CNTW'(1);
        state_next = S_SUP_CHK;
      end
      S_EMIT: begin
        // hold the item until the sink takes it
        if (!kept_stall) begin
          kept_next  = kept + 7'd1;
          state_next = last ? S_FINISH : S_START;
        end
      end
      S_FINISH: begin
        cmd.op     = OP_FLUSH;
        count_next = '0;
        kept_next  = '0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      count <= '0;
      kept  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
      kept  <= kept_next;
    end
  end

  `BNMS_ASSERT_NOW(a_emit_under_limit, kept_valid, kept < limit)
  `BNMS_ASSERT_NOW(a_count_bounded, 1'b1, count <= CNTW'(MAX_BOXES))
  `BNMS_ASSERT_NEXT(a_last_ends_batch, kept_valid && !kept_stall && last, state == S_FINISH)

endmodule

`default_nettype wire

### rtl/box_non_max_suppression.sv
// Greedy box suppression. Boxes load one item per cycle until the item marked
// final_box; the batch then runs while box_stall stays high. Each round sweeps the
// loaded boxes for the best live score (a dead entry is only checked, a live one
// is also compared, read through the single store port), then sweeps again
// testing IoU against the kept box (a dead entry is only checked, a live one runs
// the geometry, intersection, area, denominator, product and test steps of the
// staged multiply chain), then emits one kept item.
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module box_non_max_suppression import bnms_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 box_valid,
  output logic                      box_stall,
  input  wire box_in_t              box,
  output logic                      kept_valid,
  input  wire logic                 kept_stall,
  output box_out_t                  kept,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int IDXW = $clog2(MAX_BOXES);

  logic [7:0]      threshold;
  logic [6:0]      limit;
  cmd_t            cmd;
  status_t         status;
  logic [IDXW-1:0] addr;
  logic            last;
  entry_t          kept_box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd64;
      limit     <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_LIMIT:     limit     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .box_valid  (box_valid),
    .final_box  (box.final_box),
    .box_stall  (box_stall),
    .kept_valid (kept_valid),
    .kept_stall (kept_stall),
    .last       (last),
    .limit      (limit),
    .status     (status),
    .cmd        (cmd),
    .addr       (addr)
  );

  bnms_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .box       (box),
    .threshold (threshold),
    .status    (status),
    .kept_box  (kept_box)
  );

  assign kept = '{kept_left: kept_box.x1, kept_top: kept_box.y1, kept_right: kept_box.x2,
                  kept_bottom: kept_box.y2, kept_score: kept_box.score, last_kept: last};

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Box suppression testbench
// Loads batches of boxes under random idling, predicts the kept boxes with a
// greedy IoU suppression model and checks every emitted item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bnms_pkg::*;

  class kept_board;
    box_out_t   pending[$];
    box_in_t    batch[$];
    logic [7:0] thresh;
    logic [6:0] limit;
    int         errors;

    function new();
      thresh = 8'd64;
      limit = 7'd64;
      errors = 0;
    endfunction

    function longint iou(box_in_t a, box_in_t b);
      longint x1, y1, x2, y2, inter, den;
      x1 = (a.left_edge > b.left_edge) ? a.left_edge : b.left_edge;
      y1 = (a.top_edge > b.top_edge) ? a.top_edge : b.top_edge;
      x2 = (a.right_edge < b.right_edge) ? a.right_edge : b.right_edge;
      y2 = (a.bottom_edge < b.bottom_edge) ? a.bottom_edge : b.bottom_edge;
      if (x2 <= x1 || y2 <= y1) return 0;
      inter = (x2 - x1) * (y2 - y1);
      den = (longint'(a.right_edge) - a.left_edge) * (longint'(a.bottom_edge) - a.top_edge)
          + (longint'(b.right_edge) - b.left_edge) * (longint'(b.bottom_edge) - b.top_edge)
          - inter;
      if (den == 0) return 0;
      return (inter * 128) / den;
    endfunction

    function void note_box(box_in_t b);
      int order[$];
      bit dead[64];
      int j, kept_n;
      box_out_t r;
      if (batch.size() < 64) batch.push_back(b);
      if (!b.final_box) return;
      foreach (batch[i]) begin
        j = order.size();
        while (j > 0 && batch[order[j-1]].box_score < batch[i].box_score) j--;
        order.insert(j, i);
      end
      kept_n = 0;
      for (int p = 0; p < order.size() && kept_n < limit; p++) begin
        if (dead[order[p]]) continue;
        r.kept_left = batch[order[p]].left_edge;
        r.kept_top = batch[order[p]].top_edge;
        r.kept_right = batch[order[p]].right_edge;
        r.kept_bottom = batch[order[p]].bottom_edge;
        r.kept_score = batch[order[p]].box_score;
        r.last_kept = 1'b0;
        pending.push_back(r);
        kept_n++;
        for (int q = p + 1; q < order.size(); q++)
          if (!dead[order[q]] && iou(batch[order[p]], batch[order[q]]) > longint'(thresh))
            dead[order[q]] = 1;
      end
      if (kept_n > 0) pending[pending.size()-1].last_kept = 1'b1;
      batch.delete();
    endfunction

    function void check_kept(box_out_t got);
      if (pending.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        errors++;
      end else begin
        box_out_t e;
        e = pending.pop_front();
        if (got !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic box_valid = 0, kept_stall = 0, cfg_valid = 0;
  box_in_t box = '0;
  logic [CfgIndexW-1:0] cfg_index = CFG_THRESHOLD;
  logic [7:0] cfg_data = '0;
  logic box_stall, kept_valid, cfg_ready;
  box_out_t kept;
  kept_board board = new();
  bit calm = 0;
  int cycles = 0;

  box_non_max_suppression dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // random receiver stall bursts
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
      kept_stall <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk)
    if (!rst && kept_valid && !kept_stall) board.check_kept(kept);

  task automatic write_cfg(logic [CfgIndexW-1:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) board.thresh = val;
    else board.limit = val[6:0];
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40000) @(posedge clk);
  endtask

  task automatic send_box(box_in_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      box_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    box <= b;
    box_valid <= 1'b1;
    do @(posedge clk); while (box_stall);
    board.note_box(b);
    // drop valid after the batch ends; hold it for a following item
    if (b.final_box) begin
      box_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic box_in_t make_box(int mode);
    box_in_t b;
    int cx, cy, w, h;
    if (mode == 0) begin
      b.left_edge = 16'($urandom);
      b.top_edge = 16'($urandom);
      b.right_edge = 16'($urandom);
      b.bottom_edge = 16'($urandom);
      b.box_score = 16'($urandom);
    end else begin
      cx = $urandom_range(0, 4000); cy = $urandom_range(0, 4000);
      w = $urandom_range(1, 2000); h = $urandom_range(1, 2000);
      b.left_edge = 16'(cx); b.top_edge = 16'(cy);
      b.right_edge = 16'(cx + w); b.bottom_edge = 16'(cy + h);
      b.box_score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    end
    b.final_box = 1'b0;
    return b;
  endfunction

  task automatic send_batch(int n, int mode);
    box_in_t b;
    for (int i = 0; i < n; i++) begin
      b = make_box(mode);
      b.final_box = (i == n - 1);
      send_box(b);
    end
  endtask

  initial begin
    box_in_t b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes: full-range box, zero box, inverted box, identical boxes
    b = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b0}; send_box(b);
    b = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, -16'sh8000, 1'b0}; send_box(b);
    b = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'sh0000, 1'b0}; send_box(b);
    b = '{16'h0010, 16'h0010, 16'h0100, 16'h0100, 16'sh0005, 1'b0}; send_box(b);
    b = '{16'h0010, 16'h0010, 16'h0100, 16'h0100, 16'sh0005, 1'b0}; send_box(b);
    b = '{16'h0020, 16'h0020, 16'h0110, 16'h0110, 16'sh0005, 1'b1}; send_box(b);
    drain();
    // store overflow: 66 boxes, the last two dropped
    send_batch(66, 1);
    drain();
    write_cfg(CFG_THRESHOLD, 8'd0); write_cfg(CFG_LIMIT, 8'd1);
    send_batch(8, 1);
    drain();
    write_cfg(CFG_THRESHOLD, 8'd255); write_cfg(CFG_LIMIT, 8'd0);
    send_batch(4, 1);
    drain();
    write_cfg(CFG_THRESHOLD, 8'd128); write_cfg(CFG_LIMIT, 8'd64);
    send_batch(5, 0);
    drain();
    for (int k = 0; k < 40; k++) begin
      if (k % 8 == 0) begin
        drain();
        write_cfg(CFG_THRESHOLD, 8'($urandom_range(0, 140)));
        write_cfg(CFG_LIMIT, 8'($urandom_range(1, 64)));
      end
      if (k == 32) calm = 1;
      send_batch($urandom_range(1, 12), ($urandom_range(0, 4) == 0) ? 0 : 1);
      if (k % 10 == 5) drain();
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/bnms_pkg.sv
rtl/bnms_dp.sv
rtl/bnms_ctrl.sv
rtl/box_non_max_suppression.sv
verif/testbench.sv
